>>> rtl/core/ramr_pkg.sv
// Shared constants for the rational add/multiply/reduce unit.
// No dependencies; compiled first.
package ramr_pkg;

  // Operation codes carried on the input item
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  // Result field widths
  localparam int RES_NUM_WIDTH = 33;
  localparam int RES_DEN_WIDTH = 31;

endpackage

>>> rtl/core/ramr_if.sv
// Valid/ready channel interfaces for the operand and result items.
// Depends on ramr_pkg for the result field widths.
interface ramr_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic signed [OPERAND_WIDTH-1:0] num_a;
  logic signed [OPERAND_WIDTH-1:0] den_a;
  logic signed [OPERAND_WIDTH-1:0] num_b;
  logic signed [OPERAND_WIDTH-1:0] den_b;

  modport source (output valid, op, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, op, num_a, den_a, num_b, den_b, output ready);
endinterface

interface ramr_out_if;
  import ramr_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [RES_NUM_WIDTH-1:0] res_num;
  logic        [RES_DEN_WIDTH-1:0] res_den;
  logic                            zero_den_error;

  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

>>> rtl/core/ramr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by rational_add_mul_reduce to divide by the gcd.
module ramr_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CW = $clog2(WIDTH);

  logic          busy;
  logic [CW-1:0] count;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[WIDTH-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = ~diff[WIDTH];
    rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= {quo[WIDTH-2:0], ge};
        count <= count + 1'b1;
        if (count == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/rational_add_mul_reduce.sv
// Rational add/multiply with reduction to lowest terms.
// Depends on ramr_pkg, ramr_if (ramr_in_if, ramr_out_if) and ramr_divider.
//
//   channel   dir  handshake     payload
//   operands  in   valid/ready   op, num_a, den_a, num_b, den_b
//   result    out  valid/ready   res_num, res_den, zero_den_error
//
// One item at a time. The shared multiplier forms the denominator product,
// then the numerator product (multiply) or both cross products (add); COMBINE
// merges them, a binary gcd follows (one shift or subtract per cycle, up to
// about 8*W steps) and two restoring divisions divide both parts by the gcd.
// A zero denominator goes straight to FINISH, a zero numerator from GCD_TWO.
// Reset is synchronous; the result register holds a finished item while the
// sink stalls, and a new item is taken as soon as the unit is back to idle.
module rational_add_mul_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  ramr_in_if.sink    operands,
  ramr_out_if.source result
);
  import ramr_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int M  = 2 * W;
  localparam int KW = $clog2(M + 1);
  localparam int NX = M + RES_NUM_WIDTH;
  localparam int DX = M + RES_DEN_WIDTH;

  typedef enum logic [3:0] {
    IDLE, MUL_DEN, MUL_T1, MUL_T2, COMBINE, GCD_TWO, GCD_LOOP,
    DIV_NUM, DIV_DEN, FINISH
  } state_t;

  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  state_t state;

  logic         op_r;
  logic [W-1:0] na, da, nb, db;
  logic         sna, snb;
  logic [M-1:0] den_r, t1, t2, num_mag;
  logic         rneg;
  logic [M-1:0] u, v, g, q_num;
  logic [KW-1:0] k;

  logic signed [RES_NUM_WIDTH-1:0] fin_num;
  logic        [RES_DEN_WIDTH-1:0] fin_den;
  logic                            fin_err;

  logic                            out_valid;
  logic signed [RES_NUM_WIDTH-1:0] out_num;
  logic        [RES_DEN_WIDTH-1:0] out_den;
  logic                            out_err;

  // Shared multiplier
  logic [W-1:0] mul_a, mul_b;
  logic [M-1:0] prod;

  always_comb begin
    unique case (state)
      MUL_DEN: begin mul_a = da; mul_b = db; end
      MUL_T1:  begin mul_a = na; mul_b = (op_r == OP_MUL) ? nb : db; end
      default: begin mul_a = nb; mul_b = da; end
    endcase
    prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
  end

  // Combine the cross products (add) or take the product (multiply) into a signed magnitude
  logic [M-1:0] rmag_c;
  logic         rneg_c;

  always_comb begin
    if (op_r == OP_MUL) begin
      rmag_c = t1;
      rneg_c = sna ^ snb;
    end else if (sna == snb) begin
      rmag_c = t1 + t2;
      rneg_c = sna;
    end else if (t1 >= t2) begin
      rmag_c = t1 - t2;
      rneg_c = sna;
    end else begin
      rmag_c = t2 - t1;
      rneg_c = snb;
    end
  end

  // Divider hookup
  logic         div_start, div_done;
  logic [M-1:0] div_dividend, div_divisor, div_quo;
  logic [M-1:0] g_c;

  assign g_c          = u << k;
  assign div_start    = ((state == GCD_LOOP) && u[0] && (v == '0)) ||
                        ((state == DIV_NUM) && div_done);
  assign div_dividend = (state == GCD_LOOP) ? num_mag : den_r;
  assign div_divisor  = (state == GCD_LOOP) ? g_c : g;

  ramr_divider #(.WIDTH(M)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sign and resize the reduced parts
  logic [NX-1:0] num_ext, num_neg;
  logic [DX-1:0] den_ext;

  assign num_ext = {{RES_NUM_WIDTH{1'b0}}, q_num};
  assign num_neg = ~num_ext + 1'b1;
  assign den_ext = {{RES_DEN_WIDTH{1'b0}}, div_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (operands.valid) begin
            op_r <= operands.op;
            na   <= mag_of(operands.num_a);
            da   <= mag_of(operands.den_a);
            nb   <= mag_of(operands.num_b);
            db   <= mag_of(operands.den_b);
            // fold the denominator signs into the numerators
            sna  <= operands.num_a[W-1] ^ operands.den_a[W-1];
            snb  <= operands.num_b[W-1] ^ operands.den_b[W-1];
            if ((operands.den_a == '0) || (operands.den_b == '0)) begin
              fin_num <= '0;
              fin_den <= RES_DEN_WIDTH'(1);
              fin_err <= 1'b1;
              state   <= FINISH;
            end else begin
              state <= MUL_DEN;
            end
          end
        end
        MUL_DEN: begin
          den_r <= prod;
          state <= MUL_T1;
        end
        MUL_T1: begin
          t1 <= prod;
          if (op_r == OP_ADD) begin
            state <= MUL_T2;
          end else begin
            state <= COMBINE;
          end
        end
        MUL_T2: begin
          t2    <= prod;
          state <= COMBINE;
        end
        COMBINE: begin
          num_mag <= rmag_c;
          rneg    <= rneg_c;
          u       <= rmag_c;
          v       <= den_r;
          k       <= '0;
          state   <= GCD_TWO;
        end
        GCD_TWO: begin
          // finish early on a zero numerator, else strip common factors of two, counting them in k
          priority if (num_mag == '0) begin
            fin_num <= '0;
            fin_den <= RES_DEN_WIDTH'(1);
            fin_err <= 1'b0;
            state   <= FINISH;
          end else if (u[0] || v[0]) begin
            state <= GCD_LOOP;
          end else begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end
        end
        GCD_LOOP: begin
          priority if (!u[0]) begin
            u <= u >> 1;
          end else if (v == '0) begin
            g     <= g_c;
            state <= DIV_NUM;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= v;
            v <= u - v;
          end else begin
            v <= v - u;
          end
        end
        DIV_NUM: begin
          if (div_done) begin
            q_num <= div_quo;
            state <= DIV_DEN;
          end
        end
        DIV_DEN: begin
          if (div_done) begin
            fin_num <= rneg ? num_neg[RES_NUM_WIDTH-1:0] : num_ext[RES_NUM_WIDTH-1:0];
            fin_den <= den_ext[RES_DEN_WIDTH-1:0];
            fin_err <= 1'b0;
            state   <= FINISH;
          end
        end
        FINISH: begin
          // hold until the result register is free
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_num   <= fin_num;
            out_den   <= fin_den;
            out_err   <= fin_err;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign operands.ready        = (state == IDLE);
  assign result.valid          = out_valid;
  assign result.res_num        = out_num;
  assign result.res_den        = out_den;
  assign result.zero_den_error = out_err;

endmodule

>>> tb/rational_add_mul_reduce_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rational_add_mul_reduce: directed table, then random items.
// Depends on ramr_pkg, ramr_if (ramr_in_if, ramr_out_if) and the RTL of the unit.
module rational_add_mul_reduce_tb;
  import ramr_pkg::*;

  localparam int          W             = 16;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          DRAIN_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef logic signed [W-1:0] operand_t;

  localparam operand_t MIN_OP = 16'sh8000;
  localparam operand_t MAX_OP = 16'sh7FFF;

  typedef struct packed {
    logic signed [RES_NUM_WIDTH-1:0] num;
    logic        [RES_DEN_WIDTH-1:0] den;
    logic                            zero_den;
  } frac_result_t;

  localparam frac_result_t ZERO_FRAC  = '{num: '0, den: 31'd1, zero_den: 1'b0};
  localparam frac_result_t ERROR_FRAC = '{num: '0, den: 31'd1, zero_den: 1'b1};
  localparam frac_result_t ONE_FRAC   = '{num: 33'sd1, den: 31'd1, zero_den: 1'b0};

  typedef struct {
    logic         op;
    operand_t     na;
    operand_t     da;
    operand_t     nb;
    operand_t     db;
    bit           typed;
    frac_result_t want;
  } stim_row_t;

  // Rows with typed = 0 go through the predictor.
  stim_row_t directed_rows [22] = '{
    '{OP_ADD, 16'sd1,  16'sd2,   16'sd1,  16'sd3,   1'b0, '0},
    '{OP_MUL, 16'sd2,  16'sd2,   16'sd1,  16'sd1,   1'b1, ONE_FRAC},
    '{OP_ADD, 16'sd0,  16'sd5,   16'sd0,  -16'sd7,  1'b1, ZERO_FRAC},
    '{OP_MUL, 16'sd0,  16'sd3,   MAX_OP,  MIN_OP,   1'b1, ZERO_FRAC},
    '{OP_ADD, 16'sd3,  16'sd4,   -16'sd3, 16'sd4,   1'b1, ZERO_FRAC},
    '{OP_ADD, 16'sd1,  16'sd0,   16'sd1,  16'sd1,   1'b1, ERROR_FRAC},
    '{OP_MUL, 16'sd5,  16'sd7,   16'sd2,  16'sd0,   1'b1, ERROR_FRAC},
    '{OP_MUL, MIN_OP,  16'sd0,   MIN_OP,  16'sd0,   1'b1, ERROR_FRAC},
    '{OP_ADD, 16'sd0,  16'sd0,   16'sd0,  16'sd0,   1'b1, ERROR_FRAC},
    '{OP_MUL, MIN_OP,  16'sd1,   MIN_OP,  16'sd1,   1'b1,
      '{num: 33'sd1073741824, den: 31'd1, zero_den: 1'b0}},
    '{OP_ADD, MIN_OP,  16'sd1,   MIN_OP,  16'sd1,   1'b1,
      '{num: -33'sd65536, den: 31'd1, zero_den: 1'b0}},
    '{OP_MUL, MIN_OP,  MIN_OP,   MIN_OP,  MIN_OP,   1'b1, ONE_FRAC},
    '{OP_MUL, -16'sd1, -16'sd1,  -16'sd1, -16'sd1,  1'b1, ONE_FRAC},
    '{OP_ADD, MIN_OP,  -16'sd1,  MIN_OP,  -16'sd1,  1'b1,
      '{num: 33'sd65536, den: 31'd1, zero_den: 1'b0}},
    '{OP_MUL, MAX_OP,  MIN_OP,   MAX_OP,  MIN_OP,   1'b0, '0},
    '{OP_ADD, MAX_OP,  MIN_OP,   MAX_OP,  MIN_OP,   1'b0, '0},
    '{OP_ADD, 16'sd1,  MIN_OP,   16'sd1,  MAX_OP,   1'b0, '0},
    '{OP_MUL, MIN_OP,  MAX_OP,   MIN_OP,  MAX_OP,   1'b0, '0},
    '{OP_MUL, MIN_OP,  -16'sd1,  MAX_OP,  16'sd1,   1'b0, '0},
    '{OP_ADD, -16'sd5, 16'sd3,   16'sd7,  -16'sd6,  1'b0, '0},
    '{OP_ADD, 16'sd6,  16'sd4,   16'sd3,  16'sd2,   1'b0, '0},
    '{OP_ADD, MAX_OP,  16'sd1,   MAX_OP,  -16'sd1,  1'b1, ZERO_FRAC}
  };

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  frac_result_t pending_fracs [$];
  frac_result_t oldest;

  ramr_in_if #(.OPERAND_WIDTH(W)) operands_if ();
  ramr_out_if                     result_if ();

  rational_add_mul_reduce #(.OPERAND_WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_if),
    .result   (result_if)
  );

  always #4 clk = ~clk;

  // Normalize signs, combine, then reduce by the gcd.
  function automatic frac_result_t reduce_sum_or_product(logic op, operand_t na, operand_t da,
                                                         operand_t nb, operand_t db);
    longint            n1, d1, n2, d2, top, bottom;
    longint unsigned   a, b, t;
    frac_result_t      r;
    r = ZERO_FRAC;
    if (da == 0 || db == 0) begin
      return ERROR_FRAC;
    end
    n1 = na;
    d1 = da;
    n2 = nb;
    d2 = db;
    if (d1 < 0) begin
      n1 = -n1;
      d1 = -d1;
    end
    if (d2 < 0) begin
      n2 = -n2;
      d2 = -d2;
    end
    bottom = d1 * d2;
    top    = (op == OP_MUL) ? n1 * n2 : n1 * d2 + n2 * d1;
    if (top == 0) begin
      return r;
    end
    a = (top < 0) ? -top : top;
    b = bottom;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    top    = top / longint'(a);
    bottom = bottom / longint'(a);
    r.num  = top[RES_NUM_WIDTH-1:0];
    r.den  = bottom[RES_DEN_WIDTH-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 4);
    if (pick < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  // Mix zeros, full-range values, small values, extremes and values with shared factors.
  function automatic operand_t random_operand(bit for_den);
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 99);
    if (pick < (for_den ? 3 : 6)) return '0;
    if (pick < 45) return operand_t'($urandom);
    if (pick < 80) return operand_t'(int'($urandom_range(0, 48)) - 24);
    if (pick < 90) begin
      case ($urandom_range(0, 3))
        0:       return MIN_OP;
        1:       return MAX_OP;
        2:       return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    v = int'($urandom_range(1, 63)) << $urandom_range(0, 9);
    return operand_t'($urandom_range(0, 1) ? -v : v);
  endfunction

  task automatic send_item(input logic op, input operand_t na, input operand_t da,
                           input operand_t nb, input operand_t db, input bit typed,
                           input frac_result_t want, input int unsigned gap);
    if (gap != 0) begin
      operands_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands_if.valid <= 1'b1;
    operands_if.op    <= op;
    operands_if.num_a <= na;
    operands_if.den_a <= da;
    operands_if.num_b <= nb;
    operands_if.den_b <= db;
    @(posedge clk);
    while (!operands_if.ready) @(posedge clk);
    pending_fracs.push_back(typed ? want : reduce_sum_or_product(op, na, da, nb, db));
  endtask

  initial begin : stimulus
    bit no_idle;
    rst               <= 1'b1;
    operands_if.valid <= 1'b0;
    operands_if.op    <= OP_ADD;
    operands_if.num_a <= '0;
    operands_if.den_a <= '0;
    operands_if.num_b <= '0;
    operands_if.den_b <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].na, directed_rows[i].da,
                directed_rows[i].nb, directed_rows[i].db, directed_rows[i].typed,
                directed_rows[i].want, idle_len());
    end

    // Blocks of 50 items; some blocks send back to back.
    repeat (RANDOM_ITEMS / 50) begin
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        send_item(($urandom_range(0, 1) == 0) ? OP_ADD : OP_MUL,
                  random_operand(1'b0), random_operand(1'b1),
                  random_operand(1'b0), random_operand(1'b1),
                  1'b0, '0, no_idle ? 0 : idle_len());
      end
    end
    operands_if.valid <= 1'b0;

    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned run;
    int unsigned stall;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      result_if.ready <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_fracs.size() == 0) begin
        $error("result with no item outstanding: %0d/%0d zero_den_error=%0b",
               result_if.res_num, result_if.res_den, result_if.zero_den_error);
        fail_count++;
      end else begin
        oldest = pending_fracs.pop_front();
        if (result_if.res_num !== oldest.num) begin
          $error("res_num: expected %0d, got %0d", oldest.num, result_if.res_num);
          fail_count++;
        end
        if (result_if.res_den !== oldest.den) begin
          $error("res_den: expected %0d, got %0d", oldest.den, result_if.res_den);
          fail_count++;
        end
        if (result_if.zero_den_error !== oldest.zero_den) begin
          $error("zero_den_error: expected %0b, got %0b", oldest.zero_den,
                 result_if.zero_den_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_fracs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
